### rtl/core/scld_pkg.sv
`default_nettype none

package scld_pkg;

  localparam int LINE_BYTES = 16;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int LEN_W      = $clog2(LINE_BYTES) + 1;
  localparam int CHAR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int ARG_W      = 16;
  localparam int CODE_W     = 5;
  localparam int CMD_COUNT  = 23;
  localparam int MAX_PREFIX = 8;
  localparam int TEXT_W     = 8 * MAX_PREFIX;

  localparam logic [CODE_W-1:0] BAD_CODE = CODE_W'(23);

  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] BYTE_DEL   = 8'd127;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] BYTE_TILDE = 8'd126;
  localparam logic [BYTE_W-1:0] BYTE_LOW_A = 8'd97;
  localparam logic [BYTE_W-1:0] BYTE_LOW_Z = 8'd122;
  localparam logic [BYTE_W-1:0] BYTE_MINUS = 8'd45;
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] BYTE_NINE  = 8'd57;
  localparam logic [BYTE_W-1:0] UPPER_MASK = 8'h5F;

  localparam logic [1:0] KIND_CR    = 2'd0;
  localparam logic [1:0] KIND_DEL   = 2'd1;
  localparam logic [1:0] KIND_PRINT = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [1:0] GATE_NONE  = 2'd0;
  localparam logic [1:0] GATE_DAC   = 2'd1;
  localparam logic [1:0] GATE_FOCUS = 2'd2;

  localparam logic [1:0] REG_ECHO_ON       = 2'd0;
  localparam logic [1:0] REG_DAC_PRESENT   = 2'd1;
  localparam logic [1:0] REG_FOCUS_PRESENT = 2'd2;

  localparam logic [TEXT_W-1:0] CMD_TEXT [CMD_COUNT] = '{
    "?", "XPIX:", "YPIX:", "START", "MOVEX:", "MOVEY:", "X:", "Y:",
    "LASER:", "ZEROALL", "HOMEXY", "HOMEX", "HOMEY", "POWER:", "MOVEZ:",
    "Z:", "HOMEZ", "ECHO:", "XHOME:", "YHOME", "XBCOMP:", "MOTORS:",
    "SWITCHES"
  };

  localparam logic [3:0] CMD_LEN [CMD_COUNT] = '{
    4'd1, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd2, 4'd2,
    4'd6, 4'd7, 4'd6, 4'd5, 4'd5, 4'd6, 4'd6,
    4'd2, 4'd5, 4'd5, 4'd6, 4'd5, 4'd7, 4'd7,
    4'd8
  };

  localparam logic [1:0] CMD_GATE [CMD_COUNT] = '{
    GATE_NONE, GATE_NONE, GATE_NONE, GATE_NONE, GATE_NONE, GATE_NONE,
    GATE_NONE, GATE_NONE, GATE_NONE, GATE_NONE, GATE_NONE, GATE_NONE,
    GATE_NONE, GATE_DAC, GATE_FOCUS, GATE_FOCUS, GATE_FOCUS, GATE_NONE,
    GATE_NONE, GATE_NONE, GATE_NONE, GATE_NONE, GATE_NONE
  };

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] raw;
    logic [CHAR_W-1:0] chr;
  } req_t;

  typedef struct packed {
    logic echo_on;
    logic dac_present;
    logic focus_present;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] cmd_char(input int idx, input int p);
    logic [TEXT_W-1:0] t;
    int                l;
    t = CMD_TEXT[idx];
    l = int'(CMD_LEN[idx]);
    if (p < l) begin
      return BYTE_W'(t >> (8 * (l - 1 - p)));
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

### rtl/core/scld_if.sv
`default_nettype none

interface scld_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scld_out_if;
  logic               valid;
  logic               ready;
  logic               echo_valid;
  logic [7:0]         echo_byte;
  logic               send_newline;
  logic               command_valid;
  logic [4:0]         command_code;
  logic signed [15:0] argument;

  modport source (output valid, output echo_valid, output echo_byte, output send_newline,
                  output command_valid, output command_code, output argument,
                  input ready);
  modport sink   (input valid, input echo_valid, input echo_byte, input send_newline,
                  input command_valid, input command_code, input argument,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/serial_command_line_decoder_core.sv
// Serial command line decoder.
// rx carries one received byte per request; res returns exactly one result
// per byte, in order: the echo (when echo is on), and on a carriage return
// that ends a non-empty line also a line feed flag, the command code
// (23 for a bad command) and the signed decimal argument.
// Registers on the APB port: 0x0 echo_on, 0x4 dac_present, 0x8 focus_present.
// A byte passes a two-entry queue, then the line engine; an ordinary byte's
// result shows on res in the cycle after the engine takes it from the queue.
// A carriage return runs a match pass over the first min(length, 8)
// characters and, on a match, an argument pass over the rest of the line
// after the matched command, one buffer read per cycle; a full line holds
// fifteen characters.
// The line engine holds one request at a time; up to two more wait in the
// queue, so rx stays ready while the engine is busy until the queue fills.
// When res is stalled the result register holds and the engine takes no
// new byte; a decoded line waits until res takes the result.
// Reset empties the line and the queue and sets echo on, the other
// registers off.
`default_nettype none

module serial_command_line_decoder_core
  import scld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  scld_in_if.sink          rx,
  scld_out_if.source       res
);

  cfg_t       cfg;
  req_t       front_req;
  req_t       q_data;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       push;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_on       <= 1'b1;
      cfg.dac_present   <= 1'b0;
      cfg.focus_present <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_ECHO_ON:       cfg.echo_on       <= pwdata[0];
        REG_DAC_PRESENT:   cfg.dac_present   <= pwdata[0];
        REG_FOCUS_PRESENT: cfg.focus_present <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ECHO_ON:       prdata = {31'd0, cfg.echo_on};
      REG_DAC_PRESENT:   prdata = {31'd0, cfg.dac_present};
      REG_FOCUS_PRESENT: prdata = {31'd0, cfg.focus_present};
      default:           prdata = '0;
    endcase
  end

  assign rx.ready = !q_full;
  assign push     = rx.valid && !q_full;

  scld_front u_front (
    .byte_in (rx.rx_byte),
    .req     (front_req)
  );

  scld_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_req),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  scld_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

`default_nettype wire

### rtl/core/scld_front.sv
`default_nettype none

module scld_front
  import scld_pkg::*;
(
  input  wire logic [BYTE_W-1:0] byte_in,
  output      req_t              req
);

  logic [BYTE_W-1:0] folded;

  always_comb begin
    folded = byte_in;
    if (byte_in >= BYTE_LOW_A && byte_in <= BYTE_LOW_Z) begin
      folded = byte_in & UPPER_MASK;
    end
    req.raw = byte_in;
    req.chr = folded[CHAR_W-1:0];
    if (byte_in == BYTE_CR) begin
      req.kind = KIND_CR;
    end else if (byte_in == BYTE_DEL) begin
      req.kind = KIND_DEL;
    end else if (byte_in >= BYTE_SPACE && byte_in <= BYTE_TILDE) begin
      req.kind = KIND_PRINT;
    end else begin
      req.kind = KIND_OTHER;
    end
  end

endmodule

`default_nettype wire

### rtl/core/scld_fifo.sv
`default_nettype none

module scld_fifo
  import scld_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t push_data,
  output      logic full,
  input  wire logic pop,
  output      logic empty,
  output      req_t pop_data
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/scld_back.sv
`default_nettype none

module scld_back
  import scld_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_empty,
  input  wire req_t  q_data,
  output      logic  q_pop,
  scld_out_if.source res
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MATCH  = 3'd1;
  localparam logic [2:0] ST_SELECT = 3'd2;
  localparam logic [2:0] ST_ARG    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]           state;
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     pos;
  logic [LEN_W-1:0]     start;
  logic [CHAR_W-1:0]    mem [LINE_BYTES];
  logic [CHAR_W-1:0]    rd_data;
  logic                 d_vld;
  logic [LEN_W-1:0]     d_pos;
  logic [CMD_COUNT-1:0] mask;
  logic [ARG_W-1:0]     acc;
  logic                 neg;

  logic                 res_valid;
  logic                 echo_valid;
  logic [BYTE_W-1:0]    echo_byte;
  logic                 send_newline;
  logic                 command_valid;
  logic [CODE_W-1:0]    command_code;
  logic [ARG_W-1:0]     argument;

  logic                 slot;
  logic                 issue;
  logic [LEN_W-1:0]     mlim;
  logic [BYTE_W-1:0]    d_char;
  logic [CMD_COUNT-1:0] hit;
  logic                 found;
  logic [CODE_W-1:0]    sel;
  logic [LEN_W-1:0]     sel_len;
  logic                 mem_we;
  logic                 simple_load;
  logic                 done_load;
  logic [ARG_W-1:0]     acc_x10;

  assign slot   = !res_valid || res.ready;
  assign mlim   = (len > LEN_W'(MAX_PREFIX)) ? LEN_W'(MAX_PREFIX) : len;
  assign issue  = ((state == ST_MATCH) && (pos < mlim)) || ((state == ST_ARG) && (pos < len));
  assign d_char = {1'b0, rd_data};
  assign q_pop  = (state == ST_IDLE) && !q_empty && slot;
  assign simple_load = q_pop && !((q_data.kind == KIND_CR) && (len != '0));
  assign done_load   = (state == ST_DONE) && slot;
  assign mem_we = simple_load && (q_data.kind == KIND_PRINT) &&
                  (len < LEN_W'(LINE_BYTES - 1));
  assign acc_x10 = (acc << 3) + (acc << 1);

  always_comb begin
    found   = 1'b0;
    sel     = BAD_CODE;
    sel_len = '0;
    for (int i = 0; i < CMD_COUNT; i++) begin
      hit[i] = mask[i] && (LEN_W'(CMD_LEN[i]) <= len) &&
               !((CMD_GATE[i] == GATE_DAC) && !cfg.dac_present) &&
               !((CMD_GATE[i] == GATE_FOCUS) && !cfg.focus_present);
    end
    for (int i = CMD_COUNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found   = 1'b1;
        sel     = CODE_W'(i);
        sel_len = LEN_W'(CMD_LEN[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[len[ADDR_W-1:0]] <= q_data.chr;
    end
    if (issue) begin
      rd_data <= mem[pos[ADDR_W-1:0]];
    end
    d_pos <= pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      len   <= '0;
      pos   <= '0;
      d_vld <= 1'b0;
    end else begin
      d_vld <= issue;
      if (issue) begin
        pos <= pos + LEN_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_data.kind)
              KIND_CR: begin
                if (len != '0) begin
                  state <= ST_MATCH;
                  pos   <= '0;
                end
              end
              KIND_DEL: begin
                if (len != '0) begin
                  len <= len - LEN_W'(1);
                end
              end
              KIND_PRINT: begin
                if (mem_we) begin
                  len <= len + LEN_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MATCH: begin
          if (!issue && !d_vld) begin
            state <= ST_SELECT;
          end
        end
        ST_SELECT: begin
          if (found) begin
            state <= ST_ARG;
            pos   <= sel_len;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_ARG: begin
          if (!issue && !d_vld) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot) begin
            state <= ST_IDLE;
            len   <= '0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mask <= '1;
    end else if (state == ST_MATCH && d_vld) begin
      for (int i = 0; i < CMD_COUNT; i++) begin
        if ((d_pos < LEN_W'(CMD_LEN[i])) && (d_char != cmd_char(i, int'(d_pos)))) begin
          mask[i] <= 1'b0;
        end
      end
    end
    if (state == ST_SELECT) begin
      acc          <= '0;
      neg          <= 1'b0;
      start        <= sel_len;
      command_code <= sel;
    end else if (state == ST_ARG && d_vld) begin
      if ((d_pos == start) && (d_char == BYTE_MINUS)) begin
        neg <= 1'b1;
      end else if (d_char >= BYTE_ZERO && d_char <= BYTE_NINE) begin
        acc <= acc_x10 + ARG_W'(d_char - BYTE_ZERO);
      end
    end else if (simple_load) begin
      command_code <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (simple_load) begin
      echo_valid    <= cfg.echo_on;
      echo_byte     <= cfg.echo_on ? q_data.raw : '0;
      send_newline  <= 1'b0;
      command_valid <= 1'b0;
      argument      <= '0;
    end else if (done_load) begin
      echo_valid    <= cfg.echo_on;
      echo_byte     <= cfg.echo_on ? BYTE_CR : '0;
      send_newline  <= cfg.echo_on;
      command_valid <= 1'b1;
      argument      <= neg ? (ARG_W'(0) - acc) : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (simple_load || done_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign res.valid         = res_valid;
  assign res.echo_valid    = echo_valid;
  assign res.echo_byte     = echo_byte;
  assign res.send_newline  = send_newline;
  assign res.command_valid = command_valid;
  assign res.command_code  = command_code;
  assign res.argument      = argument;

`ifndef SYNTHESIS
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(LINE_BYTES - 1))
    else $error("line length beyond capacity");

  a_newline_cmd: assert property (@(posedge clk) disable iff (rst)
    (res_valid && send_newline) |-> (command_valid && echo_valid))
    else $error("line feed without a decoded command");

  a_bad_arg: assert property (@(posedge clk) disable iff (rst)
    (res_valid && command_code == BAD_CODE) |-> (argument == '0))
    else $error("bad command carries an argument");

  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    done_load |=> (len == '0 && state == ST_IDLE && res_valid))
    else $error("line not cleared after decode");
`endif

endmodule

`default_nettype wire

### verif/tb_serial_command_line_decoder_core.sv
`default_nettype none

module tb_serial_command_line_decoder_core;
  import scld_pkg::*;

  localparam int         CMD_TOTAL  = 23;
  localparam logic [4:0] CODE_BAD   = 5'd23;
  localparam int         CMD_POWER  = 13;
  localparam int         CMD_MOVEZ  = 14;
  localparam int         CMD_HOMEZ  = 16;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_HIGH  = 8'hFF;
  localparam logic [7:0] BYTE_B7    = 8'h80;

  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        send_newline;
    logic        command_valid;
    logic [4:0]  command_code;
    logic [15:0] argument;
  } decode_result_t;

  string cmd_names [CMD_TOTAL] = '{
    "?", "XPIX:", "YPIX:", "START", "MOVEX:", "MOVEY:", "X:", "Y:",
    "LASER:", "ZEROALL", "HOMEXY", "HOMEX", "HOMEY", "POWER:", "MOVEZ:",
    "Z:", "HOMEZ", "ECHO:", "XHOME:", "YHOME", "XBCOMP:", "MOTORS:",
    "SWITCHES"
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  scld_in_if  rx_ch ();
  scld_out_if res_ch ();

  serial_command_line_decoder_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_ch),
    .res     (res_ch)
  );

  logic [CHAR_W-1:0] line_mem [LINE_BYTES];
  int                line_len = 0;
  bit                echo_en = 1'b1;
  bit                dac_en = 1'b0;
  bit                focus_en = 1'b0;

  decode_result_t pending_results [$];
  decode_result_t oldest;
  int             mismatch_count = 0;
  int             bytes_sent = 0;
  bit             idle_on = 1'b1;
  int             hold_left = 0;
  int             gap_left = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic decode_result_t decode_byte(input logic [7:0] b);
    decode_result_t r;
    logic [7:0]  pc;
    logic [15:0] acc;
    int          i, k, n, pos;
    bit          hit, found, neg, enabled;
    r = '0;
    r.echo_valid = echo_en;
    r.echo_byte  = echo_en ? b : 8'h00;
    if (b == BYTE_CR && line_len > 0) begin
      r.send_newline  = echo_en;
      r.command_valid = 1'b1;
      r.command_code  = CODE_BAD;
      found = 1'b0;
      for (i = 0; i < CMD_TOTAL && !found; i++) begin
        enabled = 1'b1;
        if (i == CMD_POWER && !dac_en) enabled = 1'b0;
        if (i >= CMD_MOVEZ && i <= CMD_HOMEZ && !focus_en) enabled = 1'b0;
        n = cmd_names[i].len();
        hit = enabled && (n <= line_len);
        for (k = 0; k < n && hit; k++) begin
          pc = cmd_names[i][k];
          if ({1'b0, line_mem[k]} != pc) hit = 1'b0;
        end
        if (hit) begin
          found = 1'b1;
          r.command_code = 5'(i);
          acc = '0;
          neg = 1'b0;
          pos = n;
          if (pos < line_len) begin
            if ({1'b0, line_mem[pos]} == CH_MINUS) begin
              neg = 1'b1;
              pos++;
            end else if ({1'b0, line_mem[pos]} == CH_PLUS) begin
              pos++;
            end
          end
          for (; pos < line_len; pos++) begin
            pc = {1'b0, line_mem[pos]};
            if (pc >= CH_ZERO && pc <= CH_NINE) acc = 16'(acc * 16'd10 + 16'(pc - CH_ZERO));
          end
          r.argument = neg ? 16'(-acc) : acc;
        end
      end
      line_len = 0;
    end else if (b == BYTE_DEL) begin
      if (line_len > 0) line_len--;
    end else if (b >= BYTE_SPACE && b <= BYTE_TILDE && line_len < LINE_BYTES - 1) begin
      pc = (b >= BYTE_LOW_A && b <= BYTE_LOW_Z) ? (b & UPPER_MASK) : b;
      line_mem[line_len] = pc[CHAR_W-1:0];
      line_len++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", 32'(res_ch.echo_byte), '0);
      end else begin
        oldest = pending_results.pop_front();
        if (res_ch.echo_valid !== oldest.echo_valid)
          report_mismatch("echo_valid", 32'(res_ch.echo_valid), 32'(oldest.echo_valid));
        if (res_ch.echo_byte !== oldest.echo_byte)
          report_mismatch("echo_byte", 32'(res_ch.echo_byte), 32'(oldest.echo_byte));
        if (res_ch.send_newline !== oldest.send_newline)
          report_mismatch("send_newline", 32'(res_ch.send_newline),
                          32'(oldest.send_newline));
        if (res_ch.command_valid !== oldest.command_valid)
          report_mismatch("command_valid", 32'(res_ch.command_valid),
                          32'(oldest.command_valid));
        if (res_ch.command_code !== oldest.command_code)
          report_mismatch("command_code", 32'(res_ch.command_code),
                          32'(oldest.command_code));
        if (res_ch.argument !== oldest.argument)
          report_mismatch("argument", 32'(res_ch.argument), 32'(oldest.argument));
      end
    end
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 3);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    pending_results.push_back(decode_byte(b));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      case (idx)
        REG_ECHO_ON:       echo_en  = wdata[0];
        REG_DAC_PRESENT:   dac_en   = wdata[0];
        REG_FOCUS_PRESENT: focus_en = wdata[0];
        default: ;
      endcase
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input bit echo_v, input bit dac_v, input bit focus_v);
    logic [1:0]  regs [3];
    bit          vals [3];
    logic [31:0] rd;
    int          k;
    regs = '{REG_ECHO_ON, REG_DAC_PRESENT, REG_FOCUS_PRESENT};
    vals = '{echo_v, dac_v, focus_v};
    for (k = 0; k < 3; k++)
      apb_access(regs[k], 1'b1, {16'($urandom_range(0, 65535)), 15'd0, vals[k]}, rd);
    for (k = 0; k < 3; k++) begin
      apb_access(regs[k], 1'b0, '0, rd);
      if (rd[0] !== vals[k]) report_mismatch("register readback", rd, 32'(vals[k]));
    end
    @(posedge clk);
  endtask

  task automatic send_line();
    string      name;
    int         cut, k, ndig;
    logic [7:0] c;
    name = cmd_names[$urandom_range(0, CMD_TOTAL - 1)];
    case ($urandom_range(0, 9))
      0: begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        cut = $urandom_range(0, name.len() - 1);
        for (k = 0; k < cut; k++) send_byte(name[k]);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
        send_byte(BYTE_CR);
      end
      default: begin
        for (k = 0; k < name.len(); k++) begin
          c = name[k];
          if (c >= CH_UPPER_A && c <= CH_UPPER_Z && $urandom_range(0, 1)) c = c | CASE_BIT;
          if ($urandom_range(0, 15) == 0) begin
            send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
            send_byte(BYTE_DEL);
          end
          send_byte(c);
        end
        case ($urandom_range(0, 3))
          0: send_byte(CH_MINUS);
          1: send_byte(CH_PLUS);
          default: ;
        endcase
        ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
        repeat (ndig) begin
          if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
          send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        send_byte(BYTE_CR);
      end
    endcase
  endtask

  task automatic test_control_bytes();
    send_byte(BYTE_NUL);
    send_byte(BYTE_HIGH);
    send_byte(BYTE_B7);
    send_byte(BYTE_DEL);
    send_byte(BYTE_CR);
    drain();
  endtask

  task automatic test_edit_and_fold();
    send_text("xpix:-9");
    send_byte(BYTE_DEL);
    send_byte(CH_ZERO + 8'd7);
    send_byte(BYTE_CR);
    send_text("?+12");
    send_byte(BYTE_CR);
    send_text("Z:+3");
    send_byte(BYTE_CR);
    drain();
  endtask

  task automatic test_random_lines(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_line();
    drain();
  endtask

  task automatic test_backpressure();
    int stop_at;
    hold_left = 120;
    stop_at = bytes_sent + 40;
    while (bytes_sent < stop_at) send_line();
    drain();
  endtask

  task automatic test_config_sweep();
    int p;
    for (p = 0; p < 8; p++) begin
      set_config(p[0], p[1], p[2]);
      test_random_lines(150);
      if (p == 3) test_backpressure();
    end
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    set_config(1'b1, 1'b1, 1'b1);
    test_random_lines(180);
  endtask

  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_control_bytes();
    test_edit_and_fold();
    test_config_sweep();
    test_no_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
